@@ src/htfd_pkg.sv @@
// Shared types, constants and the CRC-8 step for the humidity/temperature frame decoder.
`timescale 1ns / 1ps

package htfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  localparam logic [2:0] PosTempHi = 3'd0;
  localparam logic [2:0] PosTempLo = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumHi = 3'd3;
  localparam logic [2:0] PosHumLo = 3'd4;
  localparam logic [2:0] PosHumCrc = 3'd5;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusTempCrc = 2'd1;
  localparam logic [1:0] StatusHumCrc = 2'd2;

  localparam logic [14:0] TempSpan = 15'd17500;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [13:0] HumSpan = 14'd10000;
  localparam logic [16:0] RawFullScale = 17'd65535;

  typedef struct packed {
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic [1:0]  status;
  } frame_t;

  localparam int unsigned FrameW = $bits(frame_t);

  // MSB-first CRC-8 over one byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/htfd_front.sv @@
// Front end: byte position tracking, CRC checking and frame assembly.
`timescale 1ns / 1ps

module htfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  output logic                byte_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_start_i,
  output logic                frame_valid_o,
  input  logic                frame_ready_i,
  output htfd_pkg::frame_t    frame_o
);

  logic [2:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] traw_q, traw_d;
  logic [15:0] hraw_q, hraw_d;
  logic        tgood_q, tgood_d;
  logic [2:0]  pos;
  logic        accept;
  logic        hum_good;

  assign byte_ready_o = frame_ready_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign pos          = (frame_start_i || pos_q > htfd_pkg::PosHumCrc) ?
                        htfd_pkg::PosTempHi : pos_q;
  assign hum_good     = (crc_q == data_byte_i);

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    traw_d  = traw_q;
    hraw_d  = hraw_q;
    tgood_d = tgood_q;
    if (accept) begin
      pos_d = (pos == htfd_pkg::PosHumCrc) ? htfd_pkg::PosTempHi : pos + 3'd1;
      case (pos)
        htfd_pkg::PosTempHi: begin
          crc_d  = htfd_pkg::crc8_step(htfd_pkg::CrcInit, data_byte_i);
          traw_d = {data_byte_i, 8'h00};
        end
        htfd_pkg::PosTempLo: begin
          crc_d  = htfd_pkg::crc8_step(crc_q, data_byte_i);
          traw_d = {traw_q[15:8], data_byte_i};
        end
        htfd_pkg::PosTempCrc: begin
          tgood_d = (crc_q == data_byte_i);
          crc_d   = htfd_pkg::CrcInit;
        end
        htfd_pkg::PosHumHi: begin
          crc_d  = htfd_pkg::crc8_step(htfd_pkg::CrcInit, data_byte_i);
          hraw_d = {data_byte_i, 8'h00};
        end
        htfd_pkg::PosHumLo: begin
          crc_d  = htfd_pkg::crc8_step(crc_q, data_byte_i);
          hraw_d = {hraw_q[15:8], data_byte_i};
        end
        default: begin
          crc_d = htfd_pkg::CrcInit;
        end
      endcase
    end
  end

  always_comb begin
    frame_o.temp_raw = traw_q;
    frame_o.hum_raw  = hraw_q;
    if (!tgood_q) begin
      frame_o.status = htfd_pkg::StatusTempCrc;
    end else if (!hum_good) begin
      frame_o.status = htfd_pkg::StatusHumCrc;
    end else begin
      frame_o.status = htfd_pkg::StatusOk;
    end
  end

  assign frame_valid_o = accept && (pos == htfd_pkg::PosHumCrc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= htfd_pkg::PosTempHi;
      crc_q   <= htfd_pkg::CrcInit;
      traw_q  <= '0;
      hraw_q  <= '0;
      tgood_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      traw_q  <= traw_d;
      hraw_q  <= hraw_d;
      tgood_q <= tgood_d;
    end
  end

endmodule

@@ src/htfd_fifo.sv @@
// Short flop-based queue between the front end and the scaling back end.
`timescale 1ns / 1ps

module htfd_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             not_full_o,
  input  logic [Width-1:0] wdata_i,
  output logic             not_empty_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign not_full_o  = (cnt_q != CntW'(Depth));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign rdata_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ src/htfd_back.sv @@
// Back end: two-stage scaling of raw words to centi-units, with output register.
`timescale 1ns / 1ps

module htfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_valid_i,
  output logic             frame_pop_o,
  input  htfd_pkg::frame_t frame_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [14:0]      temperature_centi_o,
  output logic [13:0]      humidity_centi_o,
  output logic [1:0]       frame_status_o
);

  // stage 1: products
  logic        s1_v_q;
  logic [30:0] tprod_q;
  logic [29:0] hprod_q;
  logic [1:0]  s1_status_q;

  // stage 2: output register
  logic        out_v_q;
  logic [14:0] temp_q, temp_d;
  logic [13:0] hum_q, hum_d;
  logic [1:0]  status_q;

  logic        out_adv, s1_adv;
  logic [16:0] trem, hrem;
  logic [14:0] tquo;
  logic [13:0] hquo;

  assign out_adv     = !out_v_q || res_ready_i;
  assign s1_adv      = !s1_v_q || out_adv;
  assign frame_pop_o = frame_valid_i && s1_adv;

  // x / 65535 with x = a*2^16 + b: q = a, r = a + b < 2*65535, one correction
  assign trem = {1'b0, tprod_q[15:0]} + {2'b00, tprod_q[30:16]};
  assign hrem = {1'b0, hprod_q[15:0]} + {3'b000, hprod_q[29:16]};
  assign tquo = tprod_q[30:16] + ((trem >= htfd_pkg::RawFullScale) ? 15'd1 : 15'd0);
  assign hquo = hprod_q[29:16] + ((hrem >= htfd_pkg::RawFullScale) ? 14'd1 : 14'd0);

  always_comb begin
    temp_d = '0;
    hum_d  = '0;
    if (s1_status_q == htfd_pkg::StatusOk) begin
      temp_d = tquo - htfd_pkg::TempOffset;
      hum_d  = hquo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_pop_o) begin
      tprod_q     <= 31'(frame_i.temp_raw) * 31'(htfd_pkg::TempSpan);
      hprod_q     <= 30'(frame_i.hum_raw) * 30'(htfd_pkg::HumSpan);
      s1_status_q <= frame_i.status;
    end
    if (s1_v_q && out_adv) begin
      temp_q   <= temp_d;
      hum_q    <= hum_d;
      status_q <= s1_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= frame_valid_i;
      end
      if (out_adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  assign res_valid_o         = out_v_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign frame_status_o      = status_q;

endmodule

@@ src/humidity_temp_frame_decoder.sv @@
// Top level of the humidity/temperature sensor reply decoder.
`timescale 1ns / 1ps

// Takes the six-byte sensor reply (temp hi, temp lo, temp CRC, hum hi, hum lo,
// hum CRC) at one byte per cycle while s_axis_tready is high; tuser marks
// byte 0 and restarts the frame. Each word is checked against CRC-8 (poly
// 0x31, init 0xFF). After the sixth beat one result beat carries temperature
// in 0.01 C, humidity in 0.01 %RH and a status (0 ok, 1 temperature CRC bad,
// 2 humidity CRC bad; values are zero on a bad CRC). The result passes through
// the queue, the multiply stage and the output register. s_axis_tready drops
// only when the FIFO_DEPTH-entry frame queue is full, i.e. when results back up.

module humidity_temp_frame_decoder #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
  output logic [1:0]  m_axis_tuser    // [1:0] frame_status
);

  logic             fr_push, fr_not_full, fr_not_empty, fr_pop;
  htfd_pkg::frame_t fr_wdata, fr_rdata;
  logic [14:0]      temp_centi;
  logic [13:0]      hum_centi;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (s_axis_tvalid),
    .byte_ready_o  (s_axis_tready),
    .data_byte_i   (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .frame_valid_o (fr_push),
    .frame_ready_i (fr_not_full),
    .frame_o       (fr_wdata)
  );

  htfd_fifo #(
    .Depth (FIFO_DEPTH),
    .Width (htfd_pkg::FrameW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_push),
    .not_full_o  (fr_not_full),
    .wdata_i     (fr_wdata),
    .not_empty_o (fr_not_empty),
    .pop_i       (fr_pop),
    .rdata_o     (fr_rdata)
  );

  htfd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .frame_valid_i       (fr_not_empty),
    .frame_pop_o         (fr_pop),
    .frame_i             (fr_rdata),
    .res_valid_o         (m_axis_tvalid),
    .res_ready_i         (m_axis_tready),
    .temperature_centi_o (temp_centi),
    .humidity_centi_o    (hum_centi),
    .frame_status_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, hum_centi, temp_centi};

endmodule

@@ dv/humidity_temp_frame_decoder_tb.sv @@
// Self-checking testbench for humidity_temp_frame_decoder: directed and random sensor replies.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_tb;

  localparam int unsigned RandomBeats = 1500;
  localparam int unsigned IdlePct = 36;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RxHoldCycles = 300;

  typedef struct packed {
    logic [14:0] temp_centi;
    logic [13:0] hum_centi;
    logic [1:0]  status;
  } reading_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       typed;
    reading_t   reading;
  } stim_row_t;

  localparam reading_t NoReading = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [7:0] data_byte
  logic        s_axis_tuser = 1'b0; // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // [14:0] temperature_centi, [28:15] humidity_centi
  logic [1:0]  m_axis_tuser;       // [1:0] frame_status

  // decoder shadow state
  logic [2:0]  dec_pos = htfd_pkg::PosTempHi;
  logic [7:0]  dec_crc = htfd_pkg::CrcInit;
  logic [15:0] dec_temp_raw = '0;
  logic [15:0] dec_hum_raw = '0;
  logic        dec_temp_good = 1'b0;

  reading_t    pending_readings[$];
  int unsigned error_count = 0;
  int unsigned beat_count = 0;
  bit          no_idle = 1'b0;
  int unsigned rx_hold_request = 0;

  // extremes, both CRC failures, restart mid-frame, back-to-back without frame start
  stim_row_t directed[26] = '{
    '{8'h00, 1'b1, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h81, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hAC, 1'b0, 1'b1, reading_t'{15'(-4500), 14'd10000, htfd_pkg::StatusOk}},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hAC, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h81, 1'b0, 1'b1, reading_t'{15'd13000, 14'd0, htfd_pkg::StatusOk}},
    '{8'hBE, 1'b1, 1'b0, NoReading},
    '{8'hEF, 1'b0, 1'b0, NoReading},
    '{8'h92, 1'b0, 1'b0, NoReading},
    '{8'hBE, 1'b0, 1'b0, NoReading},
    '{8'hEF, 1'b0, 1'b0, NoReading},
    '{8'h93, 1'b0, 1'b1, reading_t'{15'd0, 14'd0, htfd_pkg::StatusHumCrc}},
    '{8'h12, 1'b1, 1'b0, NoReading},
    '{8'h34, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b1, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b1, reading_t'{15'd0, 14'd0, htfd_pkg::StatusTempCrc}}
  };

  humidity_temp_frame_decoder uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[7] ? (8'(r << 1) ^ htfd_pkg::CrcPoly) : 8'(r << 1);
    return r;
  endfunction

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic decode_beat(input logic [7:0] b, input logic start,
                             output bit got, output reading_t rd);
    logic [2:0] p;
    p = (start || dec_pos > htfd_pkg::PosHumCrc) ? htfd_pkg::PosTempHi : dec_pos;
    got = 1'b0;
    rd = NoReading;
    case (p)
      htfd_pkg::PosTempHi: begin
        dec_crc = crc_byte(htfd_pkg::CrcInit, b);
        dec_temp_raw = {b, 8'h00};
      end
      htfd_pkg::PosTempLo: begin
        dec_crc = crc_byte(dec_crc, b);
        dec_temp_raw[7:0] = b;
      end
      htfd_pkg::PosTempCrc: begin
        dec_temp_good = (dec_crc == b);
        dec_crc = htfd_pkg::CrcInit;
      end
      htfd_pkg::PosHumHi: begin
        dec_crc = crc_byte(htfd_pkg::CrcInit, b);
        dec_hum_raw = {b, 8'h00};
      end
      htfd_pkg::PosHumLo: begin
        dec_crc = crc_byte(dec_crc, b);
        dec_hum_raw[7:0] = b;
      end
      default: begin
        got = 1'b1;
        if (!dec_temp_good) begin
          rd.status = htfd_pkg::StatusTempCrc;
        end else if (dec_crc != b) begin
          rd.status = htfd_pkg::StatusHumCrc;
        end else begin
          rd.status = htfd_pkg::StatusOk;
          rd.temp_centi = 15'(longint'(dec_temp_raw) * htfd_pkg::TempSpan
                              / htfd_pkg::RawFullScale - htfd_pkg::TempOffset);
          rd.hum_centi = 14'(longint'(dec_hum_raw) * htfd_pkg::HumSpan
                             / htfd_pkg::RawFullScale);
        end
        dec_crc = htfd_pkg::CrcInit;
      end
    endcase
    dec_pos = (p >= htfd_pkg::PosHumCrc) ? htfd_pkg::PosTempHi : p + 3'd1;
  endtask

  task automatic send_beat(input logic [7:0] b, input logic start,
                           input logic typed, input reading_t typed_rd);
    bit got;
    reading_t rd;
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    beat_count++;
    decode_beat(b, start, got, rd);
    if (got) pending_readings.push_back(typed ? typed_rd : rd);
  endtask

  task automatic send_random_frame();
    logic [15:0] t_raw;
    logic [15:0] h_raw;
    logic [7:0]  t_crc;
    logic [7:0]  h_crc;
    logic [7:0]  bytes_out[6];
    logic        start;
    t_raw = pick_raw();
    h_raw = pick_raw();
    t_crc = crc_byte(crc_byte(htfd_pkg::CrcInit, t_raw[15:8]), t_raw[7:0]);
    h_crc = crc_byte(crc_byte(htfd_pkg::CrcInit, h_raw[15:8]), h_raw[7:0]);
    if ($urandom_range(99) < 12) t_crc ^= 8'($urandom_range(255, 1));
    if ($urandom_range(99) < 12) h_crc ^= 8'($urandom_range(255, 1));
    bytes_out = '{t_raw[15:8], t_raw[7:0], t_crc, h_raw[15:8], h_raw[7:0], h_crc};
    foreach (bytes_out[i]) begin
      start = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
      send_beat(bytes_out[i], start, 1'b0, NoReading);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(5, 1)) send_beat(8'($urandom), 1'($urandom_range(1)), 1'b0, NoReading);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : result_sink
    reading_t got;
    reading_t want;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[14:0], m_axis_tdata[28:15], m_axis_tuser};
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, got temp %0d hum %0d status %0d",
                   $time, $signed(got.temp_centi), got.hum_centi, got.status);
          error_count++;
        end else begin
          want = pending_readings.pop_front();
          check_field("temperature_centi", $signed(want.temp_centi), $signed(got.temp_centi));
          check_field("humidity_centi", want.hum_centi, got.hum_centi);
          check_field("frame_status", want.status, got.status);
        end
      end
      if (rx_hold_request != 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_beat(directed[i].data, directed[i].start, directed[i].typed, directed[i].reading);
    end

    // sink stalls while frames keep coming, so the frame queue fills and input backs up
    rx_hold_request = RxHoldCycles;
    no_idle = 1'b1;
    repeat (10) send_random_frame();
    no_idle = 1'b0;
    pause_until_drained();

    beat_count = 0;
    while (beat_count < RandomBeats) begin
      no_idle = (beat_count >= 600 && beat_count < 900);
      if ($urandom_range(99) < 85) begin
        send_random_frame();
      end else begin
        send_noise();
      end
    end
    no_idle = 1'b0;
    pause_until_drained();

    if (error_count == 0 && pending_readings.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ humidity_temp_frame_decoder.f @@
src/htfd_pkg.sv
src/htfd_front.sv
src/htfd_fifo.sv
src/htfd_back.sv
src/humidity_temp_frame_decoder.sv
dv/humidity_temp_frame_decoder_tb.sv
